### rtl/chd_pkg.sv
// ============================================================================
// Chunked body decoder package
// Shared types, character codes, register indexes and a helper function.
// ============================================================================
package chd_pkg;

    // Width of the chunk size counter.
    localparam int SIZE_BITS = 32;

    // Width of the extension and trailer counters and their limits.
    localparam int COUNT_BITS = 16;

    // Configuration port.
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 16;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_EXTENSION_LIMIT = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_TRAILER_LIMIT   = 2'd1;

    localparam logic [COUNT_BITS-1:0] EXTENSION_LIMIT_RESET = 16'd256;
    localparam logic [COUNT_BITS-1:0] TRAILER_LIMIT_RESET   = 16'd1024;

    // Character codes.
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_SEMI  = 8'h3B;

    typedef enum logic [3:0] {
        PH_BEFORE_SIZE = 4'd0,
        PH_SIZE        = 4'd1,
        PH_EXT         = 4'd2,
        PH_SIZE_CR     = 4'd3,
        PH_DATA        = 4'd4,
        PH_AFTER_DATA  = 4'd6,
        PH_DATA_CR     = 4'd7,
        PH_AFTER_LAST  = 4'd8,
        PH_TRAILER     = 4'd9,
        PH_TRAILER_CR  = 4'd10,
        PH_LAST_CR     = 4'd11
    } phase_t;

    typedef enum logic [1:0] {
        ST_MORE = 2'd0,
        ST_DONE = 2'd1,
        ST_BAD  = 2'd2
    } status_t;

    typedef struct packed {
        phase_t                 phase;
        logic [SIZE_BITS-1:0]   chunk_remaining;
        logic [COUNT_BITS-1:0]  extension_count;
        logic [COUNT_BITS-1:0]  trailer_count;
        status_t                outcome;
    } dec_state_t;

    typedef struct packed {
        logic       payload_valid;
        logic [7:0] payload_byte;
        status_t    decode_status;
    } dec_result_t;

    localparam dec_state_t STATE_CLEAR = '{
        phase:           PH_BEFORE_SIZE,
        chunk_remaining: '0,
        extension_count: '0,
        trailer_count:   '0,
        outcome:         ST_MORE
    };

    // Returns {is_hex, digit value}.
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] r;
        begin
            r = 5'd0;
            if (c >= 8'h30 && c <= 8'h39)
            begin
                r = {1'b1, c[3:0]};
            end
            else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
            begin
                r = {1'b1, c[3:0] + 4'd9};
            end
            return r;
        end
    endfunction

endpackage

### rtl/chd_decode.sv
// ============================================================================
// Chunked body decoder: byte decode logic
// Works out the next decoder state and the result for one body byte.
// ============================================================================
module chd_decode
    import chd_pkg::*;
(
    input  dec_state_t              state_cur,
    input  logic [7:0]              byte_in,
    input  logic                    new_body,
    input  logic [COUNT_BITS-1:0]   extension_limit,
    input  logic [COUNT_BITS-1:0]   trailer_limit,
    output dec_state_t              state_next,
    output dec_result_t             result
);

    dec_state_t             cur;
    dec_state_t             nxt;
    status_t                st;
    logic                   pay;
    logic [4:0]             hex;
    logic [COUNT_BITS:0]    ext_inc;
    logic [COUNT_BITS:0]    trl_inc;
    logic                   ext_over;
    logic                   trl_over;
    logic [SIZE_BITS-1:0]   rem_dec;
    logic                   chunk_nonzero;

    always_comb
    begin
        cur = new_body ? STATE_CLEAR : state_cur;
        nxt = cur;
        st  = cur.outcome;
        pay = 1'b0;

        hex           = hex_value(byte_in);
        ext_inc       = {1'b0, cur.extension_count} + 1'b1;
        trl_inc       = {1'b0, cur.trailer_count} + 1'b1;
        ext_over      = ext_inc > {1'b0, extension_limit};
        trl_over      = trl_inc > {1'b0, trailer_limit};
        rem_dec       = cur.chunk_remaining - 1'b1;
        chunk_nonzero = cur.chunk_remaining != '0;

        if (cur.outcome == ST_MORE)
        begin
            case (cur.phase)
                PH_BEFORE_SIZE:
                begin
                    if (!hex[4])
                    begin
                        st = ST_BAD;
                    end
                    else
                    begin
                        nxt.chunk_remaining = {{(SIZE_BITS-4){1'b0}}, hex[3:0]};
                        nxt.phase           = PH_SIZE;
                    end
                end
                PH_SIZE, PH_EXT:
                begin
                    if (byte_in == CH_CR)
                    begin
                        nxt.phase = PH_SIZE_CR;
                    end
                    else if (byte_in == CH_LF)
                    begin
                        // End of the size line: data follows, or the trailer.
                        if (chunk_nonzero)
                        begin
                            nxt.phase = PH_DATA;
                        end
                        else
                        begin
                            nxt.trailer_count = '0;
                            nxt.phase         = PH_AFTER_LAST;
                        end
                    end
                    else if (cur.phase == PH_SIZE)
                    begin
                        if (byte_in == CH_SPACE || byte_in == CH_TAB || byte_in == CH_SEMI)
                        begin
                            nxt.extension_count = '0;
                            nxt.phase           = PH_EXT;
                        end
                        else if (!hex[4])
                        begin
                            st = ST_BAD;
                        end
                        else if (cur.chunk_remaining[SIZE_BITS-1 -: 4] != 4'd0)
                        begin
                            st = ST_BAD;
                        end
                        else
                        begin
                            nxt.chunk_remaining =
                                {cur.chunk_remaining[SIZE_BITS-5:0], hex[3:0]};
                        end
                    end
                    else
                    begin
                        if (ext_over || (byte_in < CH_SPACE && byte_in != CH_TAB))
                        begin
                            st = ST_BAD;
                        end
                        else
                        begin
                            nxt.extension_count = ext_inc[COUNT_BITS-1:0];
                        end
                    end
                end
                PH_SIZE_CR:
                begin
                    if (byte_in != CH_LF)
                    begin
                        st = ST_BAD;
                    end
                    else if (chunk_nonzero)
                    begin
                        nxt.phase = PH_DATA;
                    end
                    else
                    begin
                        nxt.trailer_count = '0;
                        nxt.phase         = PH_AFTER_LAST;
                    end
                end
                PH_DATA:
                begin
                    pay                 = 1'b1;
                    nxt.chunk_remaining = rem_dec;
                    if (rem_dec == '0)
                    begin
                        nxt.phase = PH_AFTER_DATA;
                    end
                end
                PH_AFTER_DATA:
                begin
                    if (byte_in == CH_CR)
                    begin
                        nxt.phase = PH_DATA_CR;
                    end
                    else if (byte_in == CH_LF)
                    begin
                        nxt.phase = PH_BEFORE_SIZE;
                    end
                    else
                    begin
                        st = ST_BAD;
                    end
                end
                PH_DATA_CR:
                begin
                    if (byte_in != CH_LF)
                    begin
                        st = ST_BAD;
                    end
                    else
                    begin
                        nxt.phase = PH_BEFORE_SIZE;
                    end
                end
                PH_AFTER_LAST:
                begin
                    if (byte_in == CH_CR)
                    begin
                        nxt.phase = PH_LAST_CR;
                    end
                    else if (byte_in == CH_LF)
                    begin
                        st = ST_DONE;
                    end
                    else if (trl_over || byte_in <= CH_SPACE)
                    begin
                        st = ST_BAD;
                    end
                    else
                    begin
                        nxt.trailer_count = trl_inc[COUNT_BITS-1:0];
                        nxt.phase         = PH_TRAILER;
                    end
                end
                PH_TRAILER:
                begin
                    if (trl_over)
                    begin
                        st = ST_BAD;
                    end
                    else
                    begin
                        nxt.trailer_count = trl_inc[COUNT_BITS-1:0];
                        if (byte_in == CH_CR)
                        begin
                            nxt.phase = PH_TRAILER_CR;
                        end
                        else if (byte_in == CH_LF)
                        begin
                            nxt.phase = PH_AFTER_LAST;
                        end
                        else if (byte_in < CH_SPACE && byte_in != CH_TAB)
                        begin
                            st = ST_BAD;
                        end
                    end
                end
                PH_TRAILER_CR:
                begin
                    if (trl_over || byte_in != CH_LF)
                    begin
                        st = ST_BAD;
                    end
                    else
                    begin
                        nxt.trailer_count = trl_inc[COUNT_BITS-1:0];
                        nxt.phase         = PH_AFTER_LAST;
                    end
                end
                PH_LAST_CR:
                begin
                    st = (byte_in == CH_LF) ? ST_DONE : ST_BAD;
                end
                default:
                begin
                    st = ST_BAD;
                end
            endcase
        end

        nxt.outcome = st;
    end

    assign state_next           = nxt;
    assign result.payload_valid = pay;
    assign result.payload_byte  = pay ? byte_in : 8'd0;
    assign result.decode_status = st;

endmodule

### rtl/chd_out_stage.sv
// ============================================================================
// Chunked body decoder: result register
// Holds one result beat; a new beat is loaded when the register is empty or
// is drained in the same cycle, so a stalled beat holds off the input side.
// ============================================================================
module chd_out_stage
    import chd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load,
    input  dec_result_t result_in,
    output logic        take_ok,
    output logic        out_valid,
    input  logic        out_ready,
    output dec_result_t result_out
);

    logic        valid_reg;
    logic        valid_next;
    dec_result_t result_reg;

    // A new beat may be loaded when the register is empty or is being drained.
    assign take_ok    = !valid_reg || out_ready;
    assign valid_next = load ? 1'b1 : (out_ready ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result_in;
        end
    end

    assign out_valid  = valid_reg;
    assign result_out = result_reg;

endmodule

### rtl/http_chunked_body_decoder_top.sv
// ============================================================================
// HTTP chunked body decoder
// Decodes a chunked message body one byte per beat into payload and status.
// ============================================================================
//
// Usage
//   Body bytes enter on the input channel (in_valid / in_ready) with byte_in
//   and new_body; new_body set restarts the decoder before that byte is taken.
//   Every input beat produces exactly one result beat on the output channel
//   (out_valid / out_ready): payload_valid, payload_byte and decode_status
//   (need more, body complete, invalid data). Once complete or invalid the
//   status is sticky until a beat carries new_body.
//   The result is registered: a byte accepted at one edge has its result on the
//   outputs after that edge. Throughput is one byte per clock; the decode
//   state and the single result register are the only stages, so the rate
//   is set by the result register being free or drained in the same cycle.
//   When the receiver stalls, the result register holds its beat and
//   in_ready falls until it is taken.
//   The user must write the limits via cfg_write / cfg_index / cfg_data only
//   while idle, not enforced; indexes beyond the trailer limit are ignored.
//   Reset clears the decode state, empties the result register and returns
//   the limits to 256 extension bytes and 1024 trailer bytes.
//
module http_chunked_body_decoder_top
    import chd_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,

    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [7:0]                  byte_in,
    input  logic                        new_body,

    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        payload_valid,
    output logic [7:0]                  payload_byte,
    output logic [1:0]                  decode_status,

    input  logic                        cfg_write,
    input  logic [CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [CFG_DATA_BITS-1:0]    cfg_data
);

    // Limits written through the configuration port.
    logic [COUNT_BITS-1:0] extension_limit_reg;
    logic [COUNT_BITS-1:0] trailer_limit_reg;

    // Decoder state, advanced once per accepted byte.
    dec_state_t  state_reg;
    dec_state_t  state_next;
    dec_result_t dec_result;
    dec_result_t out_result;
    logic        accept;

    assign accept = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            extension_limit_reg <= EXTENSION_LIMIT_RESET;
            trailer_limit_reg   <= TRAILER_LIMIT_RESET;
        end
        else if (cfg_write)
        begin
            if (cfg_index == CFG_EXTENSION_LIMIT)
            begin
                extension_limit_reg <= cfg_data;
            end
            else if (cfg_index == CFG_TRAILER_LIMIT)
            begin
                trailer_limit_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= STATE_CLEAR;
        end
        else if (accept)
        begin
            state_reg <= state_next;
        end
    end

    // The decode logic sees the byte on the ports and the stored state.
    chd_decode u_decode (
        .state_cur       (state_reg),
        .byte_in         (byte_in),
        .new_body        (new_body),
        .extension_limit (extension_limit_reg),
        .trailer_limit   (trailer_limit_reg),
        .state_next      (state_next),
        .result          (dec_result)
    );

    // The result register decouples the receiver from the input side.
    chd_out_stage u_out_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (accept),
        .result_in  (dec_result),
        .take_ok    (in_ready),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .result_out (out_result)
    );

    assign payload_valid = out_result.payload_valid;
    assign payload_byte  = out_result.payload_byte;
    assign decode_status = out_result.decode_status;

endmodule

### rtl/chd_checker.sv
// ============================================================================
// Chunked body decoder checker
// Port-level assertions on the result channel, bound to the top level.
// ============================================================================
module chd_checker
    import chd_pkg::*;
(
    input logic         clk,
    input logic         rst_n,
    input logic         out_valid,
    input logic         out_ready,
    input logic         payload_valid,
    input logic [7:0]   payload_byte,
    input logic [1:0]   decode_status
);

    // A stalled result beat keeps its contents.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(payload_valid)
            && $stable(payload_byte) && $stable(decode_status))
        else $error("result beat changed while stalled");

    // Payload only ever comes out while the body is still running.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && payload_valid |-> decode_status == ST_MORE)
        else $error("payload with a final status");

    // Non-payload beats carry a zero byte, and the status code is defined.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (payload_valid || payload_byte == 8'd0)
            && (decode_status == ST_MORE || decode_status == ST_DONE
                || decode_status == ST_BAD))
        else $error("malformed result beat");

    // An edge seen in reset leaves the result register empty for the next one.
    assert property (@(posedge clk) !rst_n |=> !out_valid)
        else $error("result beat straight after reset");

endmodule

bind http_chunked_body_decoder_top chd_checker u_chd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .payload_valid (payload_valid),
    .payload_byte  (payload_byte),
    .decode_status (decode_status)
);
